### sv/tno_pkg.sv
// Types and constants shared by the telnet option negotiation block.
package tno_pkg;

  // Request op codes
  localparam logic [3:0] OP_GOT_WILL   = 4'd0;
  localparam logic [3:0] OP_GOT_WONT   = 4'd1;
  localparam logic [3:0] OP_GOT_DO     = 4'd2;
  localparam logic [3:0] OP_GOT_DONT   = 4'd3;
  localparam logic [3:0] OP_EN_LOCAL   = 4'd4;
  localparam logic [3:0] OP_EN_REMOTE  = 4'd5;
  localparam logic [3:0] OP_DIS_LOCAL  = 4'd6;
  localparam logic [3:0] OP_DIS_REMOTE = 4'd7;
  localparam logic [3:0] OP_QUERY      = 4'd8;

  // Verbs sent to the peer
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  // Q states
  localparam logic [2:0] Q_NO         = 3'd0;
  localparam logic [2:0] Q_ASK_ON     = 3'd1;
  localparam logic [2:0] Q_ASK_ON_OFF = 3'd2;
  localparam logic [2:0] Q_YES        = 3'd3;
  localparam logic [2:0] Q_ASK_OFF    = 3'd4;
  localparam logic [2:0] Q_ASK_OFF_ON = 3'd5;

  // Per-side event kinds
  localparam logic [1:0] K_AGREE   = 2'd0;
  localparam logic [1:0] K_REFUSE  = 2'd1;
  localparam logic [1:0] K_ENABLE  = 2'd2;
  localparam logic [1:0] K_DISABLE = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] option_code;
    logic       lazy;
  } req_t;

  typedef struct packed {
    logic       send_valid;
    logic [1:0] send_verb;
    logic [7:0] option_out;
    logic       toggle_valid;
    logic       toggle_remote;
    logic       toggle_on;
    logic       local_on;
    logic       remote_on;
  } rsp_t;

  typedef struct packed {
    logic       l_lazy;
    logic [2:0] l_q;
    logic       r_lazy;
    logic [2:0] r_q;
  } entry_t;

  typedef struct packed {
    logic [2:0] q;
    logic       lz;
    logic       send;
    logic [1:0] verb;
    logic       tog;
    logic       tog_on;
  } side_res_t;

  function automatic logic q_is_on(logic [2:0] q);
    return (q == Q_YES) || (q == Q_ASK_OFF) || (q == Q_ASK_OFF_ON);
  endfunction

endpackage

### sv/telnet_option_negotiation.sv
// Top level: per-option Q-method negotiation table with one request per cycle while responses are taken.
//
// Request channel (req_valid/req_ready/req) carries an op, an option number
// and a lazy flag. Response channel (rsp_valid/rsp_ready/rsp) returns exactly
// one beat per request: the verb to send if any, a toggle event if any, and
// the enabled status of both sides after the update.
// A request is registered into the input stage when it is accepted; its
// response is registered into the output register when that stage advances.
// Throughput: one request per cycle, sustained while the receiver does not
// stall, including repeated requests for the same option; a one-entry bypass
// register covers the table's registered read port, so each request does one
// read-modify-write. Reset clears the per-entry valid bits at once; an entry
// never written reads as both sides NO with lazy clear, so no clearing pass
// is needed. When the receiver stalls, the response holds in the output
// register, the request in flight waits in the input stage, and req_ready
// drops while that stage is occupied, until the output register frees up.
// Options at or above NUM_OPTIONS change nothing and report both sides off.
module telnet_option_negotiation #(
  parameter int NUM_OPTIONS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tno_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tno_pkg::rsp_t rsp
);

  localparam int IDX_W = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

  tno_pkg::entry_t mem [NUM_OPTIONS];
  logic [NUM_OPTIONS-1:0] vld;

  logic            s1_valid;
  tno_pkg::req_t   s1;
  logic            s1_in_range;
  logic            s1_vld;
  logic            s1_fwd;
  tno_pkg::entry_t rd_entry;
  tno_pkg::entry_t fwd_entry;

  logic            s1_adv;
  logic            req_acc;
  logic            req_in_range;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  tno_pkg::entry_t   cur;
  tno_pkg::entry_t   entry_next;
  tno_pkg::side_res_t sr;
  tno_pkg::rsp_t     rsp_next;
  logic              active;
  logic              remote;
  logic [1:0]        kind;

  function automatic tno_pkg::side_res_t side_step(logic [2:0] q, logic lz, logic rmt,
                                                   logic [1:0] knd, logic lazy_in);
    tno_pkg::side_res_t r;
    logic [1:0] pos;
    logic [1:0] neg;
    r.q      = q;
    r.lz     = lz;
    r.send   = 1'b0;
    r.verb   = tno_pkg::VERB_WILL;
    r.tog    = 1'b0;
    r.tog_on = 1'b0;
    pos = rmt ? tno_pkg::VERB_DO : tno_pkg::VERB_WILL;
    neg = rmt ? tno_pkg::VERB_DONT : tno_pkg::VERB_WONT;
    unique case (knd)
      tno_pkg::K_AGREE: begin
        unique case (q)
          tno_pkg::Q_NO: begin
            r.send = 1'b1; r.verb = neg;
          end
          tno_pkg::Q_ASK_OFF: r.q = tno_pkg::Q_NO;
          tno_pkg::Q_ASK_OFF_ON: begin
            r.q = tno_pkg::Q_YES; r.tog = 1'b1; r.tog_on = 1'b1;
          end
          tno_pkg::Q_ASK_ON: begin
            r.send = lz; r.verb = pos;
            r.q = tno_pkg::Q_YES; r.tog = 1'b1; r.tog_on = 1'b1;
          end
          tno_pkg::Q_ASK_ON_OFF: begin
            r.send = 1'b1; r.verb = neg;
            r.q = tno_pkg::Q_ASK_OFF; r.tog = 1'b1; r.tog_on = 1'b1;
          end
          default: ;
        endcase
      end
      tno_pkg::K_REFUSE: begin
        unique case (q)
          tno_pkg::Q_YES: begin
            r.send = 1'b1; r.verb = neg;
            r.q = tno_pkg::Q_NO; r.tog = 1'b1;
          end
          tno_pkg::Q_ASK_OFF, tno_pkg::Q_ASK_ON, tno_pkg::Q_ASK_ON_OFF: r.q = tno_pkg::Q_NO;
          tno_pkg::Q_ASK_OFF_ON: begin
            r.send = !lz; r.verb = pos; r.q = tno_pkg::Q_ASK_ON;
          end
          default: ;
        endcase
      end
      tno_pkg::K_ENABLE: begin
        unique case (q)
          tno_pkg::Q_NO: begin
            r.q = tno_pkg::Q_ASK_ON; r.lz = lazy_in;
            r.send = !lazy_in; r.verb = pos;
          end
          tno_pkg::Q_ASK_OFF: r.q = tno_pkg::Q_ASK_OFF_ON;
          tno_pkg::Q_ASK_ON: begin
            r.send = lz && !lazy_in; r.verb = pos; r.lz = lazy_in;
          end
          tno_pkg::Q_ASK_ON_OFF: r.q = tno_pkg::Q_ASK_ON;
          default: ;
        endcase
      end
      tno_pkg::K_DISABLE: begin
        unique case (q)
          tno_pkg::Q_YES: begin
            r.send = 1'b1; r.verb = neg;
            r.q = tno_pkg::Q_ASK_OFF; r.lz = 1'b0; r.tog = 1'b1;
          end
          tno_pkg::Q_ASK_OFF_ON: r.q = tno_pkg::Q_ASK_OFF;
          tno_pkg::Q_ASK_ON: begin
            r.q = lz ? tno_pkg::Q_NO : tno_pkg::Q_ASK_ON_OFF; r.lz = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (!r.send) r.verb = tno_pkg::VERB_WILL;
    return r;
  endfunction

  // Handshake and stage control
  assign s1_adv       = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready    = !s1_valid || s1_adv;
  assign req_acc      = req_valid && req_ready;
  assign req_in_range = {1'b0, req.option_code} < 9'(NUM_OPTIONS);
  assign rd_idx       = req.option_code[IDX_W-1:0];
  assign wr_idx       = s1.option_code[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1          <= req;
      s1_in_range <= req_in_range;
      s1_vld      <= vld[rd_idx];
      s1_fwd      <= s1_adv && s1_in_range && (req.option_code == s1.option_code);
      fwd_entry   <= entry_next;
    end
  end

  // Table: write back on advance, registered read on accept
  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_range) begin
      mem[wr_idx] <= entry_next;
    end
    if (req_acc) begin
      rd_entry <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (s1_adv && s1_in_range) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  // Request decode
  always_comb begin
    active = s1_in_range;
    remote = 1'b0;
    kind   = tno_pkg::K_AGREE;
    unique case (s1.op)
      tno_pkg::OP_GOT_WILL:   begin remote = 1'b1; kind = tno_pkg::K_AGREE;   end
      tno_pkg::OP_GOT_WONT:   begin remote = 1'b1; kind = tno_pkg::K_REFUSE;  end
      tno_pkg::OP_GOT_DO:     begin remote = 1'b0; kind = tno_pkg::K_AGREE;   end
      tno_pkg::OP_GOT_DONT:   begin remote = 1'b0; kind = tno_pkg::K_REFUSE;  end
      tno_pkg::OP_EN_LOCAL:   begin remote = 1'b0; kind = tno_pkg::K_ENABLE;  end
      tno_pkg::OP_EN_REMOTE:  begin remote = 1'b1; kind = tno_pkg::K_ENABLE;  end
      tno_pkg::OP_DIS_LOCAL:  begin remote = 1'b0; kind = tno_pkg::K_DISABLE; end
      tno_pkg::OP_DIS_REMOTE: begin remote = 1'b1; kind = tno_pkg::K_DISABLE; end
      default:                active = 1'b0;
    endcase
  end

  // Entry update and response
  always_comb begin
    cur = s1_fwd ? fwd_entry : (s1_vld ? rd_entry : '0);
    sr  = side_step(remote ? cur.r_q : cur.l_q, remote ? cur.r_lazy : cur.l_lazy,
                    remote, kind, s1.lazy);
    if (!active) begin
      sr.send   = 1'b0;
      sr.verb   = tno_pkg::VERB_WILL;
      sr.tog    = 1'b0;
      sr.tog_on = 1'b0;
    end
    entry_next = cur;
    if (active && remote) begin
      entry_next.r_q    = sr.q;
      entry_next.r_lazy = sr.lz;
    end else if (active) begin
      entry_next.l_q    = sr.q;
      entry_next.l_lazy = sr.lz;
    end
    rsp_next.send_valid    = sr.send;
    rsp_next.send_verb     = sr.verb;
    rsp_next.option_out    = s1.option_code;
    rsp_next.toggle_valid  = sr.tog;
    rsp_next.toggle_remote = sr.tog && remote;
    rsp_next.toggle_on     = sr.tog_on;
    rsp_next.local_on      = s1_in_range && tno_pkg::q_is_on(entry_next.l_q);
    rsp_next.remote_on     = s1_in_range && tno_pkg::q_is_on(entry_next.r_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_toggle_off_sends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.toggle_valid && !rsp.toggle_on |-> rsp.send_valid)
    else $error("toggle off without a verb sent");

  a_verb_side: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.toggle_valid && rsp.send_valid |-> rsp.send_verb[1] == rsp.toggle_remote)
    else $error("verb sent for the wrong side");

  a_toggle_on_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.toggle_valid && rsp.toggle_on |->
      (rsp.toggle_remote ? rsp.remote_on : rsp.local_on))
    else $error("toggled on but side reported off");

  a_no_bad_q: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_in_range |-> entry_next.l_q <= tno_pkg::Q_ASK_OFF_ON &&
      entry_next.r_q <= tno_pkg::Q_ASK_OFF_ON)
    else $error("illegal Q state written to table");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_in_range |=> !rsp.send_valid && !rsp.toggle_valid &&
      !rsp.local_on && !rsp.remote_on)
    else $error("out-of-range option produced an effect");
`endif

endmodule

### verif/negotiation_checker.sv
// Reply predictor and checker for the telnet option negotiation block.
module negotiation_checker #(
  parameter int NUM_OPTIONS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  tno_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  tno_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            replies_seen,
  output int            verbs_seen,
  output int            toggles_seen
);

  typedef struct packed {
    logic [2:0] q;
    logic       lz;
    logic       send;
    logic [1:0] verb;
    logic       tog;
    logic       tog_on;
  } side_step_t;

  tno_pkg::entry_t option_state [NUM_OPTIONS];
  tno_pkg::rsp_t   expected_replies [$];
  int     mismatches = 0;
  int     replies = 0;
  int     verbs = 0;
  int     toggles = 0;

  function automatic logic side_enabled(logic [2:0] q);
    return (q == tno_pkg::Q_YES) || (q == tno_pkg::Q_ASK_OFF) || (q == tno_pkg::Q_ASK_OFF_ON);
  endfunction

  function automatic side_step_t step_side(logic [2:0] q, logic lz, logic remote,
                                           logic [1:0] kind, logic lazy_in);
    side_step_t s;
    logic [1:0] yes_verb;
    logic [1:0] no_verb;
    s        = '0;
    s.q      = q;
    s.lz     = lz;
    yes_verb = remote ? tno_pkg::VERB_DO : tno_pkg::VERB_WILL;
    no_verb  = remote ? tno_pkg::VERB_DONT : tno_pkg::VERB_WONT;
    case (kind)
      tno_pkg::K_AGREE: begin
        case (q)
          tno_pkg::Q_NO: begin
            s.send = 1'b1;
            s.verb = no_verb;
          end
          tno_pkg::Q_ASK_OFF: s.q = tno_pkg::Q_NO;
          tno_pkg::Q_ASK_OFF_ON: begin
            s.q      = tno_pkg::Q_YES;
            s.tog    = 1'b1;
            s.tog_on = 1'b1;
          end
          tno_pkg::Q_ASK_ON: begin
            // lazy enable acknowledges the peer's offer
            s.send   = lz;
            s.verb   = yes_verb;
            s.q      = tno_pkg::Q_YES;
            s.tog    = 1'b1;
            s.tog_on = 1'b1;
          end
          tno_pkg::Q_ASK_ON_OFF: begin
            s.send   = 1'b1;
            s.verb   = no_verb;
            s.q      = tno_pkg::Q_ASK_OFF;
            s.tog    = 1'b1;
            s.tog_on = 1'b1;
          end
          default: ;
        endcase
      end
      tno_pkg::K_REFUSE: begin
        case (q)
          tno_pkg::Q_YES: begin
            s.send = 1'b1;
            s.verb = no_verb;
            s.q    = tno_pkg::Q_NO;
            s.tog  = 1'b1;
          end
          tno_pkg::Q_ASK_OFF, tno_pkg::Q_ASK_ON, tno_pkg::Q_ASK_ON_OFF: s.q = tno_pkg::Q_NO;
          tno_pkg::Q_ASK_OFF_ON: begin
            s.send = !lz;
            s.verb = yes_verb;
            s.q    = tno_pkg::Q_ASK_ON;
          end
          default: ;
        endcase
      end
      tno_pkg::K_ENABLE: begin
        case (q)
          tno_pkg::Q_NO: begin
            s.q    = tno_pkg::Q_ASK_ON;
            s.lz   = lazy_in;
            s.send = !lazy_in;
            s.verb = yes_verb;
          end
          tno_pkg::Q_ASK_OFF: s.q = tno_pkg::Q_ASK_OFF_ON;
          tno_pkg::Q_ASK_ON: begin
            s.send = lz && !lazy_in;
            s.verb = yes_verb;
            s.lz   = lazy_in;
          end
          tno_pkg::Q_ASK_ON_OFF: s.q = tno_pkg::Q_ASK_ON;
          default: ;
        endcase
      end
      default: begin
        case (q)
          tno_pkg::Q_YES: begin
            s.send = 1'b1;
            s.verb = no_verb;
            s.q    = tno_pkg::Q_ASK_OFF;
            s.lz   = 1'b0;
            s.tog  = 1'b1;
          end
          tno_pkg::Q_ASK_OFF_ON: s.q = tno_pkg::Q_ASK_OFF;
          tno_pkg::Q_ASK_ON: begin
            s.q  = lz ? tno_pkg::Q_NO : tno_pkg::Q_ASK_ON_OFF;
            s.lz = 1'b0;
          end
          default: ;
        endcase
      end
    endcase
    return s;
  endfunction

  // Applies one request to the table copy and returns the reply it must produce.
  function automatic tno_pkg::rsp_t predict_reply(tno_pkg::req_t r);
    tno_pkg::rsp_t   y;
    tno_pkg::entry_t e;
    side_step_t      s;
    logic            remote;
    logic [1:0]      kind;
    logic            acts;
    y             = '0;
    y.option_out  = r.option_code;
    if (r.option_code >= NUM_OPTIONS) return y;
    e      = option_state[r.option_code];
    acts   = 1'b1;
    remote = 1'b0;
    kind   = tno_pkg::K_AGREE;
    case (r.op)
      tno_pkg::OP_GOT_WILL:   begin remote = 1'b1; kind = tno_pkg::K_AGREE;   end
      tno_pkg::OP_GOT_WONT:   begin remote = 1'b1; kind = tno_pkg::K_REFUSE;  end
      tno_pkg::OP_GOT_DO:     begin remote = 1'b0; kind = tno_pkg::K_AGREE;   end
      tno_pkg::OP_GOT_DONT:   begin remote = 1'b0; kind = tno_pkg::K_REFUSE;  end
      tno_pkg::OP_EN_LOCAL:   begin remote = 1'b0; kind = tno_pkg::K_ENABLE;  end
      tno_pkg::OP_EN_REMOTE:  begin remote = 1'b1; kind = tno_pkg::K_ENABLE;  end
      tno_pkg::OP_DIS_LOCAL:  begin remote = 1'b0; kind = tno_pkg::K_DISABLE; end
      tno_pkg::OP_DIS_REMOTE: begin remote = 1'b1; kind = tno_pkg::K_DISABLE; end
      default: acts = 1'b0;
    endcase
    if (acts) begin
      if (remote) begin
        s        = step_side(e.r_q, e.r_lazy, 1'b1, kind, r.lazy);
        e.r_q    = s.q;
        e.r_lazy = s.lz;
      end else begin
        s        = step_side(e.l_q, e.l_lazy, 1'b0, kind, r.lazy);
        e.l_q    = s.q;
        e.l_lazy = s.lz;
      end
      y.send_valid    = s.send;
      y.send_verb     = s.send ? s.verb : tno_pkg::VERB_WILL;
      y.toggle_valid  = s.tog;
      y.toggle_remote = s.tog & remote;
      y.toggle_on     = s.tog & s.tog_on;
      option_state[r.option_code] = e;
    end
    y.local_on  = side_enabled(e.l_q);
    y.remote_on = side_enabled(e.r_q);
    return y;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tno_pkg::rsp_t want;
    if (rst) begin
      foreach (option_state[i]) option_state[i] = '0;
      expected_replies.delete();
    end else begin
      if (req_valid && req_ready) expected_replies.push_back(predict_reply(req));
      if (rsp_valid && rsp_ready) begin
        replies++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          $error("reply beat for option %0d with none expected", rsp.option_out);
        end else begin
          want = expected_replies.pop_front();
          check_field("send_valid", 8'(want.send_valid), 8'(rsp.send_valid));
          check_field("send_verb", 8'(want.send_verb), 8'(rsp.send_verb));
          check_field("option_out", want.option_out, rsp.option_out);
          check_field("toggle_valid", 8'(want.toggle_valid), 8'(rsp.toggle_valid));
          check_field("toggle_remote", 8'(want.toggle_remote), 8'(rsp.toggle_remote));
          check_field("toggle_on", 8'(want.toggle_on), 8'(rsp.toggle_on));
          check_field("local_on", 8'(want.local_on), 8'(rsp.local_on));
          check_field("remote_on", 8'(want.remote_on), 8'(rsp.remote_on));
          if (want.send_valid) verbs++;
          if (want.toggle_valid) toggles++;
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_replies.size();
    replies_seen <= replies;
    verbs_seen   <= verbs;
    toggles_seen <= toggles;
  end

endmodule

### verif/tb_top.sv
// Testbench top: drives requests and reply backpressure, reports the verdict.
module tb_top;

  localparam int         OPTION_COUNT = 256;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         PHASE_BEATS  = 570;
  localparam logic [3:0] OP_CODE_MAX  = 4'hF;  // top of the unused op range

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  tno_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  tno_pkg::rsp_t rsp;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  bit hold_armed        = 1'b0;
  int requests_sent     = 0;
  int cycle_count       = 0;

  int fail_count;
  int pending;
  int replies_seen;
  int verbs_seen;
  int toggles_seen;

  telnet_option_negotiation #(
    .NUM_OPTIONS(OPTION_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  negotiation_checker #(
    .NUM_OPTIONS(OPTION_COUNT)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .pending     (pending),
    .replies_seen(replies_seen),
    .verbs_seen  (verbs_seen),
    .toggles_seen(toggles_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Reply side: random backpressure plus one long hold-off when armed.
  initial begin : reply_pacing
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  task automatic send_beat(tno_pkg::req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_request(logic [3:0] op, logic [7:0] option_code, logic lazy);
    tno_pkg::req_t r;
    r.op          = op;
    r.option_code = option_code;
    r.lazy        = lazy;
    send_beat(r);
  endtask

  // Random requests on a small rotating set of options so entries walk
  // through all Q states, with some stray options and queries mixed in.
  task automatic run_random_phase(int s_idle, int r_idle, bit hold);
    int            counted;
    int            roll;
    int            focus [4];
    tno_pkg::req_t r;
    sender_idle_pct   = s_idle;
    receiver_idle_pct = r_idle;
    hold_armed        = hold;
    counted           = 0;
    foreach (focus[i]) focus[i] = $urandom_range(0, 255);
    while (counted < PHASE_BEATS) begin
      if (requests_sent % 48 == 0) foreach (focus[i]) focus[i] = $urandom_range(0, 255);
      roll = $urandom_range(0, 99);
      if (roll < 84) r.op = 4'($urandom_range(tno_pkg::OP_GOT_WILL, tno_pkg::OP_DIS_REMOTE));
      else if (roll < 94) r.op = tno_pkg::OP_QUERY;
      else r.op = 4'($urandom_range(tno_pkg::OP_QUERY + 1, OP_CODE_MAX));
      if ($urandom_range(0, 99) < 12) r.option_code = 8'($urandom_range(0, 255));
      else r.option_code = 8'(focus[$urandom_range(0, 3)]);
      r.lazy = 1'($urandom_range(0, 1));
      send_beat(r);
      counted++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct   = 10;
    receiver_idle_pct = 46;
    send_request(tno_pkg::OP_QUERY, 8'd0, 1'b0);
    send_request(tno_pkg::OP_EN_LOCAL, 8'd0, 1'b0);
    send_request(tno_pkg::OP_EN_LOCAL, 8'd0, 1'b0);
    send_request(tno_pkg::OP_GOT_DO, 8'd0, 1'b0);
    send_request(tno_pkg::OP_EN_LOCAL, 8'd0, 1'b1);
    send_request(tno_pkg::OP_GOT_DONT, 8'd0, 1'b0);   // DONT while YES answers WONT
    send_request(tno_pkg::OP_EN_LOCAL, 8'd255, 1'b1); // lazy flag kept from NO
    send_request(tno_pkg::OP_EN_LOCAL, 8'd255, 1'b0);
    send_request(tno_pkg::OP_DIS_LOCAL, 8'd255, 1'b0);
    send_request(tno_pkg::OP_EN_LOCAL, 8'd255, 1'b1);
    send_request(tno_pkg::OP_GOT_DO, 8'd255, 1'b0);
    send_request(tno_pkg::OP_DIS_LOCAL, 8'd255, 1'b0);
    send_request(tno_pkg::OP_EN_LOCAL, 8'd255, 1'b0);
    send_request(tno_pkg::OP_GOT_DONT, 8'd255, 1'b0);
    send_request(tno_pkg::OP_EN_REMOTE, 8'd1, 1'b1);
    send_request(tno_pkg::OP_GOT_WILL, 8'd1, 1'b0);
    send_request(tno_pkg::OP_DIS_REMOTE, 8'd1, 1'b1);
    send_request(tno_pkg::OP_GOT_WONT, 8'd1, 1'b0);
    send_request(tno_pkg::OP_EN_REMOTE, 8'd2, 1'b0);
    send_request(tno_pkg::OP_DIS_REMOTE, 8'd2, 1'b0);
    send_request(tno_pkg::OP_GOT_WILL, 8'd2, 1'b0);
    send_request(tno_pkg::OP_GOT_WILL, 8'd3, 1'b0);
    send_request(tno_pkg::OP_DIS_REMOTE, 8'd3, 1'b0);
    send_request(4'(tno_pkg::OP_QUERY + 1), 8'd128, 1'b1);
    send_request(OP_CODE_MAX, 8'd127, 1'b1);

    run_random_phase(10, 46, 1'b0);
    run_random_phase(46, 10, 1'b0);
    run_random_phase(0, 0, 1'b1);

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests over three idle mixes, one with a %0d-cycle reply stall.",
             requests_sent, HOLD_CYCLES);
    $display("Checked %0d replies: %0d carried a verb, %0d a toggle; %0d mismatches.",
             replies_seen, verbs_seen, toggles_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
